/* hdl/cot_pkg.sv */
// Shared constants and types for the capsule overlap test pipeline.
// No dependencies; imported by cot_div, capsule_overlap_test and the bench.
`default_nettype none
package cot_pkg;

  // segment parameters s and t are unsigned Q0.24 in [0, 1.0]
  localparam int FRAC_BITS = 24;
  localparam logic [FRAC_BITS:0] FRAC_ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

  // packed port widths
  localparam int IN_BITS  = 384;
  localparam int OUT_BITS = 72;

  // geometry carried alongside the arithmetic
  typedef struct packed {
    logic signed [32:0] d1x;
    logic signed [32:0] d1y;
    logic signed [32:0] d1z;
    logic signed [32:0] rx;
    logic signed [33:0] ry;
    logic signed [32:0] rz;
    logic signed [32:0] h;
    logic               hz;
  } seg_t;

endpackage
`default_nettype wire

/* hdl/cot_mul.sv */
// Two-stage signed multiplier: four half-width partial products, then their sum.
// Depends on nothing but the clock enable of the surrounding pipeline.
`default_nettype none
module cot_mul #(
  parameter int AW = 33,
  parameter int BW = 33
) (
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire logic signed [AW-1:0]    a,
  input  wire logic signed [BW-1:0]    b,
  output logic signed [AW+BW-1:0]      p
);
  localparam int KA = AW / 2;
  localparam int KB = BW / 2;
  localparam int PW = AW + BW;

  logic signed [AW-KA-1:0] ah;
  logic signed [KA:0]      al;
  logic signed [BW-KB-1:0] bh;
  logic signed [KB:0]      bl;

  logic signed [AW-KA+BW-KB-1:0] pp_hh;
  logic signed [AW-KA+KB:0]      pp_hl;
  logic signed [KA+BW-KB:0]      pp_lh;
  logic signed [KA+KB+1:0]       pp_ll;

  // split operands: signed high halves, zero-extended low halves
  assign ah = a[AW-1:KA];
  assign al = $signed({1'b0, a[KA-1:0]});
  assign bh = b[BW-1:KB];
  assign bl = $signed({1'b0, b[KB-1:0]});

  // stage 1: partial products
  always_ff @(posedge clk) begin
    if (en) begin
      pp_hh <= ah * bh;
      pp_hl <= ah * bl;
      pp_lh <= al * bh;
      pp_ll <= al * bl;
    end
  end

  // stage 2: shifted sum
  always_ff @(posedge clk) begin
    if (en) begin
      p <= (PW'(pp_hh) <<< (KA + KB)) + (PW'(pp_hl) <<< KA) + (PW'(pp_lh) <<< KB)
           + PW'(pp_ll);
    end
  end

endmodule
`default_nettype wire

/* hdl/cot_div.sv */
// Pipelined clamped fraction divider: one quotient bit per stage, Q0.24 result.
// Depends on cot_pkg for the fraction width.
`default_nettype none
module cot_div #(
  parameter int W = 70
) (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire logic signed [W-1:0]          num,
  input  wire logic signed [W-1:0]          den,
  output logic [cot_pkg::FRAC_BITS:0]       q
);
  import cot_pkg::*;
  localparam int N = FRAC_BITS;

  logic [W-1:0] rem  [0:N];
  logic [W-1:0] dv   [0:N];
  logic [N-1:0] qb   [0:N];
  logic         zr   [0:N];
  logic         sat  [0:N];

  // entry stage: zero or negative gives 0, num at or above den gives 1.0
  always_ff @(posedge clk) begin
    if (en) begin
      zr[0]  <= num[W-1] || (num == '0);
      sat[0] <= (num >= den);
      rem[0] <= num;
      dv[0]  <= den;
      qb[0]  <= '0;
    end
  end

  // restoring steps
  for (genvar i = 1; i <= N; i++) begin : g_step
    logic [W:0] sh;
    logic [W:0] diff;
    logic       ge;

    assign sh   = {rem[i-1], 1'b0};
    assign diff = sh - {1'b0, dv[i-1]};
    assign ge   = (sh >= {1'b0, dv[i-1]});

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i] <= ge ? diff[W-1:0] : sh[W-1:0];
        qb[i]  <= {qb[i-1][N-2:0], ge};
        dv[i]  <= dv[i-1];
        zr[i]  <= zr[i-1];
        sat[i] <= sat[i-1];
      end
    end
  end

  assign q = zr[N] ? '0 : (sat[N] ? FRAC_ONE : {1'b0, qb[N]});

endmodule
`default_nettype wire

/* hdl/cot_delay.sv */
// Enabled delay line that carries side data beside the arithmetic stages.
// No dependencies.
`default_nettype none
module cot_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 1
) (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire logic [W-1:0] d,
  output logic [W-1:0]      q
);
  logic [W-1:0] dl [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (en) begin
      dl[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        dl[i] <= dl[i-1];
      end
    end
  end

  assign q = dl[DEPTH-1];

endmodule
`default_nettype wire

/* hdl/capsule_overlap_test.sv */
// Capsule overlap test: squared closest distance between two segments and hit flag.
// Accepts one input word per cycle whenever no finished output word is held.
// Depth is set by the two 25-stage fraction dividers in series (s, then t).
// The whole pipeline advances together; it stalls only while an output word waits.
// Reset (rst, synchronous) clears all valid bits; data registers are not reset.
// Depends on cot_pkg, cot_mul, cot_div and cot_delay.
`default_nettype none
module capsule_overlap_test (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // seg_a_x, seg_a_y, seg_a_z, seg_b_x, seg_b_y, seg_b_z, cap_radius(31),
  // foot_x, foot_y, foot_z, body_radius(31), half_height(31), zero pad
  input  wire logic [cot_pkg::IN_BITS-1:0]   s_tdata,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // hit, sq_distance(64), zero pad
  output logic [cot_pkg::OUT_BITS-1:0]       m_tdata
);
  import cot_pkg::*;

  localparam int NST = 70;

  logic            en;
  logic [NST:1]    vld;
  logic            o_valid;
  logic            o_hit;
  logic [63:0]     o_dist;

  // input fields
  logic signed [31:0] ax, ay, az, bx, by, bz, fx, fy, fz;
  logic [30:0]        crad, brad, hh;

  assign ax   = s_tdata[31:0];
  assign ay   = s_tdata[63:32];
  assign az   = s_tdata[95:64];
  assign bx   = s_tdata[127:96];
  assign by   = s_tdata[159:128];
  assign bz   = s_tdata[191:160];
  assign crad = s_tdata[222:192];
  assign fx   = s_tdata[254:223];
  assign fy   = s_tdata[286:255];
  assign fz   = s_tdata[318:287];
  assign brad = s_tdata[349:319];
  assign hh   = s_tdata[380:350];

  // global advance: move unless a finished word is held
  assign en       = !o_valid || m_tready;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      o_valid <= 1'b0;
    end else if (en) begin
      vld     <= {vld[NST-1:1], s_tvalid};
      o_valid <= vld[NST];
    end
  end

  // stage 1: differences, defender axis
  seg_t        st1;
  logic [31:0] rs1;

  always_ff @(posedge clk) begin
    if (en) begin
      st1.d1x <= 33'(bx) - 33'(ax);
      st1.d1y <= 33'(by) - 33'(ay);
      st1.d1z <= 33'(bz) - 33'(az);
      st1.rx  <= 33'(ax) - 33'(fx);
      st1.ry  <= 34'(ay) - 34'(fy) - $signed({3'b000, brad});
      st1.rz  <= 33'(az) - 33'(fz);
      st1.h   <= $signed({1'b0, hh, 1'b0}) - $signed({1'b0, brad, 1'b0});
      st1.hz  <= (hh == brad);
      rs1     <= 32'(crad) + 32'(brad);
    end
  end

  // stages 2-3: dot product terms
  logic signed [65:0] m_xr, m_zr, m_xx, m_zz, m_yy, m_hy, m_rr;
  logic signed [66:0] m_yr;

  cot_mul #(.AW(33), .BW(33)) u_xr (.clk, .en, .a(st1.d1x), .b(st1.rx),  .p(m_xr));
  cot_mul #(.AW(33), .BW(33)) u_zr (.clk, .en, .a(st1.d1z), .b(st1.rz),  .p(m_zr));
  cot_mul #(.AW(33), .BW(33)) u_xx (.clk, .en, .a(st1.d1x), .b(st1.d1x), .p(m_xx));
  cot_mul #(.AW(33), .BW(33)) u_zz (.clk, .en, .a(st1.d1z), .b(st1.d1z), .p(m_zz));
  cot_mul #(.AW(33), .BW(33)) u_yy (.clk, .en, .a(st1.d1y), .b(st1.d1y), .p(m_yy));
  cot_mul #(.AW(33), .BW(34)) u_yr (.clk, .en, .a(st1.d1y), .b(st1.ry),  .p(m_yr));
  cot_mul #(.AW(33), .BW(33)) u_hy (.clk, .en, .a(st1.h),   .b(st1.d1y), .p(m_hy));
  cot_mul #(.AW(33), .BW(33)) u_rr (.clk, .en, .a($signed({1'b0, rs1})),
                                    .b($signed({1'b0, rs1})), .p(m_rr));

  // stages 4-6: sums and divider operands
  logic signed [66:0] hdot4, hlen4, yr4, hdot5, hlen5;
  logic signed [65:0] yy4, hy4, hy5;
  logic signed [67:0] alen5, cdot5;
  logic signed [69:0] n1_6, d1_6, na_6, da_6, nb_6;

  always_ff @(posedge clk) begin
    if (en) begin
      hdot4 <= 67'(m_xr) + 67'(m_zr);
      hlen4 <= 67'(m_xx) + 67'(m_zz);
      yy4   <= m_yy;
      yr4   <= m_yr;
      hy4   <= m_hy;
      alen5 <= 68'(hlen4) + 68'(yy4);
      cdot5 <= 68'(hdot4) + 68'(yr4);
      hdot5 <= hdot4;
      hlen5 <= hlen4;
      hy5   <= hy4;
      n1_6  <= -70'(hdot5);
      d1_6  <= 70'(hlen5);
      na_6  <= -70'(cdot5);
      da_6  <= 70'(alen5);
      nb_6  <= 70'(hy5) - 70'(cdot5);
    end
  end

  // stages 7-31: candidate attacker parameters
  logic [FRAC_BITS:0] s1_31, sa_31, sb_31;

  cot_div #(.W(70)) u_div_s1 (.clk, .en, .num(n1_6), .den(d1_6), .q(s1_31));
  cot_div #(.W(70)) u_div_sa (.clk, .en, .num(na_6), .den(da_6), .q(sa_31));
  cot_div #(.W(70)) u_div_sb (.clk, .en, .num(nb_6), .den(da_6), .q(sb_31));

  seg_t st31, st33, st60, st61, st63;

  cot_delay #(.W($bits(seg_t)), .DEPTH(30)) u_dl_st31 (.clk, .en, .d(st1),  .q(st31));
  cot_delay #(.W($bits(seg_t)), .DEPTH(2))  u_dl_st33 (.clk, .en, .d(st31), .q(st33));
  cot_delay #(.W($bits(seg_t)), .DEPTH(27)) u_dl_st60 (.clk, .en, .d(st33), .q(st60));
  cot_delay #(.W($bits(seg_t)), .DEPTH(1))  u_dl_st61 (.clk, .en, .d(st60), .q(st61));
  cot_delay #(.W($bits(seg_t)), .DEPTH(2))  u_dl_st63 (.clk, .en, .d(st61), .q(st63));

  // stages 32-35: defender parameter numerator and denominator
  logic signed [58:0] m_ys;
  logic signed [59:0] tn34, td34;
  logic signed [60:0] tn35, td35;
  logic               rneg36, rpos36;

  cot_mul #(.AW(33), .BW(26)) u_ys (.clk, .en, .a(st31.d1y),
                                    .b($signed({1'b0, s1_31})), .p(m_ys));

  always_ff @(posedge clk) begin
    if (en) begin
      tn34 <= 60'(m_ys) + (60'(st33.ry) <<< FRAC_BITS);
      td34 <= 60'(st33.h) <<< FRAC_BITS;
      // fold a downward axis onto a positive denominator
      if (td34[59]) begin
        tn35 <= -61'(tn34);
        td35 <= -61'(td34);
      end else begin
        tn35 <= 61'(tn34);
        td35 <= 61'(td34);
      end
      rneg36 <= tn35[60];
      rpos36 <= (tn35 > td35);
    end
  end

  // stages 36-60: defender parameter
  logic [FRAC_BITS:0]       t_60;
  logic [3*FRAC_BITS+2:0]   s_60;
  logic [1:0]               reg_60;

  cot_div #(.W(61)) u_div_t (.clk, .en, .num(tn35), .den(td35), .q(t_60));

  cot_delay #(.W(3*FRAC_BITS+3), .DEPTH(29)) u_dl_s (.clk, .en,
    .d({s1_31, sa_31, sb_31}), .q(s_60));
  cot_delay #(.W(2), .DEPTH(24)) u_dl_reg (.clk, .en, .d({rneg36, rpos36}), .q(reg_60));

  // stage 61: pick the clamped pair
  logic [FRAC_BITS:0] s61, t61;

  always_ff @(posedge clk) begin
    if (en) begin
      priority if (st60.hz || reg_60[1]) begin
        s61 <= s_60[2*FRAC_BITS+1:FRAC_BITS+1];
        t61 <= '0;
      end else if (reg_60[0]) begin
        s61 <= s_60[FRAC_BITS:0];
        t61 <= FRAC_ONE;
      end else begin
        s61 <= s_60[3*FRAC_BITS+2:2*FRAC_BITS+2];
        t61 <= t_60;
      end
    end
  end

  // stages 62-63: offset terms
  logic signed [58:0] m_xs, m_ys2, m_zs, m_ht;

  cot_mul #(.AW(33), .BW(26)) u_xs  (.clk, .en, .a(st61.d1x), .b($signed({1'b0, s61})),
                                     .p(m_xs));
  cot_mul #(.AW(33), .BW(26)) u_ys2 (.clk, .en, .a(st61.d1y), .b($signed({1'b0, s61})),
                                     .p(m_ys2));
  cot_mul #(.AW(33), .BW(26)) u_zs  (.clk, .en, .a(st61.d1z), .b($signed({1'b0, s61})),
                                     .p(m_zs));
  cot_mul #(.AW(33), .BW(26)) u_ht  (.clk, .en, .a(st61.h),   .b($signed({1'b0, t61})),
                                     .p(m_ht));

  // stages 64-70: offset, rounding, squares, saturating sum
  logic signed [60:0] dx64, dz64, dy64, dx65, dy65, dz65;
  logic signed [58:0] ht64;
  logic [59:0]        ax66, ay66, az66;
  logic [31:0]        qx67, qy67, qz67;
  logic               ox67, oy67, oz67;
  logic [63:0]        sx68, sy68, sz68, sxy69, sz69, dist70;
  logic [63:0]        rsq70;
  logic [60:0]        rx_r, ry_r, rz_r;
  logic [64:0]        sum_xy, sum_all;

  assign rx_r    = 61'(ax66) + 61'(FRAC_ONE >> 1);
  assign ry_r    = 61'(ay66) + 61'(FRAC_ONE >> 1);
  assign rz_r    = 61'(az66) + 61'(FRAC_ONE >> 1);
  assign sum_xy  = 65'(sx68) + 65'(sy68);
  assign sum_all = 65'(sxy69) + 65'(sz69);

  always_ff @(posedge clk) begin
    if (en) begin
      dx64  <= (61'(st63.rx) <<< FRAC_BITS) + 61'(m_xs);
      dz64  <= (61'(st63.rz) <<< FRAC_BITS) + 61'(m_zs);
      dy64  <= (61'(st63.ry) <<< FRAC_BITS) + 61'(m_ys2);
      ht64  <= m_ht;
      dx65  <= dx64;
      dz65  <= dz64;
      dy65  <= dy64 - 61'(ht64);
      ax66  <= dx65[60] ? 60'(-dx65) : 60'(dx65);
      ay66  <= dy65[60] ? 60'(-dy65) : 60'(dy65);
      az66  <= dz65[60] ? 60'(-dz65) : 60'(dz65);
      // round half away from zero to Q16.16
      qx67  <= rx_r[55:24];
      qy67  <= ry_r[55:24];
      qz67  <= rz_r[55:24];
      ox67  <= |rx_r[60:56];
      oy67  <= |ry_r[60:56];
      oz67  <= |rz_r[60:56];
      sx68  <= ox67 ? '1 : 64'(qx67) * 64'(qx67);
      sy68  <= oy67 ? '1 : 64'(qy67) * 64'(qy67);
      sz68  <= oz67 ? '1 : 64'(qz67) * 64'(qz67);
      sxy69 <= sum_xy[64] ? '1 : sum_xy[63:0];
      sz69  <= sz68;
      dist70 <= sum_all[64] ? '1 : sum_all[63:0];
    end
  end

  cot_delay #(.W(64), .DEPTH(67)) u_dl_rsq (.clk, .en, .d(m_rr[63:0]), .q(rsq70));

  // output word register
  always_ff @(posedge clk) begin
    if (en) begin
      o_dist <= dist70;
      o_hit  <= (dist70 <= rsq70);
    end
  end

  assign m_tvalid = o_valid;
  assign m_tdata  = {7'b0, o_dist, o_hit};

  // checks
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> vld == $past(vld))
    else $error("valid bits moved during a stall");

  a_region_excl: assert property (@(posedge clk) disable iff (rst)
    vld[60] |-> !(reg_60[1] && reg_60[0]))
    else $error("defender parameter both below and above range");

  a_s1_range: assert property (@(posedge clk) disable iff (rst)
    vld[31] |-> (s1_31 <= FRAC_ONE) && (sa_31 <= FRAC_ONE) && (sb_31 <= FRAC_ONE))
    else $error("attacker parameter outside unit range");

  a_flat_axis: assert property (@(posedge clk) disable iff (rst)
    vld[61] && st61.hz |-> t61 == '0)
    else $error("zero-length axis with nonzero defender parameter");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> vld == '0 && !m_tvalid)
    else $error("pipeline not empty after reset");

endmodule
`default_nettype wire

/* tb/capsule_overlap_test_tb.sv */
// Self-checking bench for capsule_overlap_test: directed table, then random capsule queries.
// Output words are checked against a typed answer, else a bit-exact distance and hit model.
// Depends on cot_pkg and the capsule_overlap_test RTL.
`default_nettype none
module capsule_overlap_test_tb;
  import cot_pkg::*;

  localparam int LIMIT_CYCLES = 300000;
  localparam int RANDOM_ITEMS = 1730;
  localparam int TAIL_CYCLES  = 150;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic        hit;
    logic [63:0] sq_dist;
  } verdict_t;

  // one directed row: twelve fields, then an optional typed answer
  typedef struct {
    longint ax, ay, az, bx, by, bz, crad, fx, fy, fz, brad, hh;
    bit     typed;
    bit     hit;
    logic [63:0] sq_dist;
  } query_row_t;

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [IN_BITS-1:0]  s_tdata;
  logic                m_tvalid;
  logic                m_tready;
  logic [OUT_BITS-1:0] m_tdata;

  verdict_t    verdict_q[$];
  bit          typed_q[$];
  int          errors = 0;
  int          accepted = 0;
  longint      cycles = 0;
  bit          hold_done = 0;

  capsule_overlap_test u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // ---------------- distance model ----------------
  function automatic longint frac_quot(wide_t num, wide_t den);
    longint q;
    q = 0;
    if (num <= 0) return 0;
    if (num >= den) return longint'(1) << FRAC_BITS;
    for (int i = 0; i < FRAC_BITS; i++) begin
      q = q << 1;
      num = num <<< 1;
      if (num >= den) begin
        num = num - den;
        q = q | 1;
      end
    end
    return q;
  endfunction

  // defender parameter; side is -1 below the axis, +1 above it, 0 within
  function automatic longint axis_param(longint d1y, longint s, longint ry, longint h,
                                        output int side);
    wide_t num, den;
    num = wide_t'(d1y) * wide_t'(s) + (wide_t'(ry) <<< FRAC_BITS);
    den = wide_t'(h) <<< FRAC_BITS;
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    side = 0;
    if (num < 0) begin
      side = -1;
      return 0;
    end
    if (num > den) begin
      side = 1;
      return longint'(1) << FRAC_BITS;
    end
    return frac_quot(num, den);
  endfunction

  function automatic logic [63:0] comp_square(wide_t d);
    wide_t m, q;
    logic [63:0] ql;
    m = (d < 0) ? -d : d;
    q = (m + (wide_t'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (q >= (wide_t'(1) <<< 32)) return '1;
    ql = q[63:0];
    return ql * ql;
  endfunction

  function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic verdict_t closest_approach(logic [IN_BITS-1:0] w);
    longint ax, ay, az, bx, by, bz, crad, fx, fy, fz, brad, hh;
    longint d1x, d1y, d1z, rx, ry, rz, h, s, t;
    wide_t hdot, hlen, alen, cdot, dx, dy, dz;
    logic [63:0] rsum;
    int side;
    verdict_t v;
    ax = longint'($signed(w[31:0]));     ay = longint'($signed(w[63:32]));
    az = longint'($signed(w[95:64]));    bx = longint'($signed(w[127:96]));
    by = longint'($signed(w[159:128]));  bz = longint'($signed(w[191:160]));
    crad = longint'(w[222:192]);
    fx = longint'($signed(w[254:223]));  fy = longint'($signed(w[286:255]));
    fz = longint'($signed(w[318:287]));
    brad = longint'(w[349:319]);         hh = longint'(w[380:350]);
    d1x = bx - ax;  d1y = by - ay;  d1z = bz - az;
    rx = ax - fx;   ry = ay - fy - brad;  rz = az - fz;
    h = 2 * hh - 2 * brad;
    hdot = wide_t'(d1x) * wide_t'(rx) + wide_t'(d1z) * wide_t'(rz);
    hlen = wide_t'(d1x) * wide_t'(d1x) + wide_t'(d1z) * wide_t'(d1z);
    alen = hlen + wide_t'(d1y) * wide_t'(d1y);
    cdot = hdot + wide_t'(d1y) * wide_t'(ry);
    s = 0;
    t = 0;
    side = 0;
    if (alen == 0) begin
      if (h != 0) t = axis_param(d1y, 0, ry, h, side);
    end else if (h == 0) begin
      s = frac_quot(-cdot, alen);
    end else begin
      s = (hlen == 0) ? 0 : frac_quot(-hdot, hlen);
      t = axis_param(d1y, s, ry, h, side);
      if (side < 0) begin
        t = 0;
        s = frac_quot(-cdot, alen);
      end else if (side > 0) begin
        t = longint'(1) << FRAC_BITS;
        s = frac_quot(wide_t'(h) * wide_t'(d1y) - cdot, alen);
      end
    end
    dx = (wide_t'(rx) <<< FRAC_BITS) + wide_t'(d1x) * wide_t'(s);
    dy = (wide_t'(ry) <<< FRAC_BITS) + wide_t'(d1y) * wide_t'(s) - wide_t'(h) * wide_t'(t);
    dz = (wide_t'(rz) <<< FRAC_BITS) + wide_t'(d1z) * wide_t'(s);
    v.sq_dist = add_sat(add_sat(comp_square(dx), comp_square(dy)), comp_square(dz));
    rsum = 64'(crad) + 64'(brad);
    v.hit = (v.sq_dist <= rsum * rsum);
    return v;
  endfunction

  function automatic logic [IN_BITS-1:0] pack_query(query_row_t r);
    logic [IN_BITS-1:0] w;
    w = '0;
    w[31:0] = r.ax[31:0];     w[63:32] = r.ay[31:0];    w[95:64] = r.az[31:0];
    w[127:96] = r.bx[31:0];   w[159:128] = r.by[31:0];  w[191:160] = r.bz[31:0];
    w[222:192] = r.crad[30:0];
    w[254:223] = r.fx[31:0];  w[286:255] = r.fy[31:0];  w[318:287] = r.fz[31:0];
    w[349:319] = r.brad[30:0];
    w[380:350] = r.hh[30:0];
    return w;
  endfunction

  localparam longint NEG = -64'sd2147483648;
  localparam longint POS = 64'sd2147483647;
  localparam longint RMX = 64'sd2147483647;
  localparam longint ONE = 64'sd65536;

  // directed rows; typed answers only where obvious
  query_row_t directed[] = '{
    // everything zero: both points coincide
    '{0,0,0, 0,0,0, 0, 0,0,0, 0,0, 1, 1'b1, 64'd0},
    // points at opposite x extremes
    '{NEG,0,0, NEG,0,0, 0, POS,0,0, 0,0, 1, 1'b0, 64'hFFFF_FFFE_0000_0001},
    // x and z extremes overflow the sum: saturation
    '{NEG,0,NEG, NEG,0,NEG, 0, POS,0,POS, 0,0, 1, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF},
    // largest radii, everything else zero
    '{0,0,0, 0,0,0, RMX, 0,0,0, RMX,0, 1, 1'b1, 64'd0},
    // attacker is a point, defender upright
    '{3*ONE,5*ONE,0, 3*ONE,5*ONE,0, ONE, 0,0,0, ONE,4*ONE, 0, 0, 0},
    '{ONE,-9*ONE,ONE, ONE,-9*ONE,ONE, 0, 0,0,0, ONE,4*ONE, 0, 0, 0},
    '{ONE,90*ONE,ONE, ONE,90*ONE,ONE, 0, 0,0,0, ONE,4*ONE, 0, 0, 0},
    // defender axis collapses to a point
    '{-5*ONE,ONE,2*ONE, 5*ONE,3*ONE,-2*ONE, ONE/2, 0,0,0, 2*ONE,2*ONE, 0, 0, 0},
    // parallel: attacker vertical
    '{2*ONE,-ONE,0, 2*ONE,7*ONE,0, ONE/2, 0,0,0, ONE,3*ONE, 0, 0, 0},
    // general crossing
    '{-4*ONE,2*ONE,ONE, 4*ONE,3*ONE,-ONE, ONE, 0,0,0, ONE/2,2*ONE, 0, 0, 0},
    // general, closest below the axis
    '{-4*ONE,-8*ONE,ONE, 4*ONE,-6*ONE,ONE, ONE, 0,0,0, ONE,2*ONE, 0, 0, 0},
    // general, closest above the axis
    '{-4*ONE,20*ONE,ONE, 4*ONE,25*ONE,2*ONE, ONE, 0,0,0, ONE,2*ONE, 0, 0, 0},
    // inverted defender
    '{-3*ONE,ONE,0, 3*ONE,2*ONE,ONE, ONE, ONE,0,0, 5*ONE,ONE, 0, 0, 0},
    // extreme endpoints and sizes
    '{NEG,NEG,NEG, POS,POS,POS, RMX, NEG,POS,NEG, RMX,RMX, 0, 0, 0},
    '{POS,NEG,POS, NEG,POS,NEG, 0, POS,NEG,POS, 0,RMX, 0, 0, 0},
    '{NEG,POS,0, POS,NEG,0, RMX, 0,0,0, 0,RMX, 0, 0, 0},
    // just touching radii
    '{2*ONE,ONE,0, 2*ONE,ONE,0, ONE, 0,0,0, ONE,2*ONE, 0, 0, 0},
    // rounding of half-units
    '{1,1,1, 3,-1,2, 1, 0,0,0, 1,1, 0, 0, 0}
  };

  // ---------------- random stimulus ----------------
  function automatic longint near_coord(longint base, int spread);
    return base + longint'($urandom_range(2 * spread)) - spread;
  endfunction

  function automatic query_row_t random_query();
    query_row_t r;
    int mode, sp;
    mode = $urandom_range(9);
    sp = (mode < 5) ? 8 * 65536 : (mode < 8 ? 64 : 4000 * 65536);
    r.typed = 0;
    r.hit = 0;
    r.sq_dist = 0;
    if (mode == 9) begin
      // raw bits
      r.ax = $urandom; r.ay = $urandom; r.az = $urandom;
      r.bx = $urandom; r.by = $urandom; r.bz = $urandom;
      r.fx = $urandom; r.fy = $urandom; r.fz = $urandom;
      r.crad = $urandom; r.brad = $urandom; r.hh = $urandom;
      return r;
    end
    r.fx = $signed($urandom); r.fy = $signed($urandom) >>> 2; r.fz = $signed($urandom);
    r.fx = r.fx >>> 2;
    r.fz = r.fz >>> 2;
    r.ax = near_coord(r.fx, sp); r.ay = near_coord(r.fy, sp); r.az = near_coord(r.fz, sp);
    case ($urandom_range(5))
      0: begin r.bx = r.ax; r.by = r.ay; r.bz = r.az; end
      1: begin r.bx = r.ax; r.by = near_coord(r.ay, sp); r.bz = r.az; end
      default: begin
        r.bx = near_coord(r.ax, sp); r.by = near_coord(r.ay, sp); r.bz = near_coord(r.az, sp);
      end
    endcase
    r.crad = $urandom_range(sp / 2);
    r.brad = $urandom_range(sp / 2);
    r.hh = ($urandom_range(7) == 0) ? r.brad : $urandom_range(sp);
    return r;
  endfunction

  // ---------------- driving ----------------
  task automatic offer_query(logic [IN_BITS-1:0] w);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= w;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic idle_gap(int n);
    if (n == 0) return;
    @(negedge clk);
    s_tvalid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // ---------------- checking ----------------
  task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
    errors++;
    $display("mismatch on %s: expected %h, got %h", what, want, got);
  endtask

  always @(posedge clk) begin
    verdict_t v;
    if (!rst) begin
      cycles <= cycles + 1;
      if (s_tvalid && s_tready) begin
        accepted <= accepted + 1;
        if (typed_q.size() != 0 && typed_q[0]) begin
          void'(typed_q.pop_front());
        end else begin
          if (typed_q.size() != 0) void'(typed_q.pop_front());
          verdict_q = {verdict_q, closest_approach(s_tdata)};
        end
      end
      if (m_tvalid && m_tready) begin
        if (verdict_q.size() == 0) begin
          report_mismatch("unexpected word", 64'd0, m_tdata[64:1]);
        end else begin
          v = verdict_q.pop_front();
          if (m_tdata[0] !== v.hit) report_mismatch("hit", 64'(v.hit), 64'(m_tdata[0]));
          if (m_tdata[64:1] !== v.sq_dist) begin
            report_mismatch("sq_distance", v.sq_dist, m_tdata[64:1]);
          end
        end
      end
    end
  end

  // receiver: shifting duty cycles, one long hold-off to back up the pipeline
  initial begin
    int mode, hold;
    m_tready = 1'b0;
    mode = 0;
    hold = 0;
    forever begin
      @(negedge clk);
      if (cycles % 64 == 0) mode = $urandom_range(3);
      if (!hold_done && accepted >= 400) begin
        hold_done = 1;
        hold = 300;
      end
      if (hold > 0) begin
        hold--;
        m_tready <= 1'b0;
      end else begin
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= ($urandom_range(3) != 0);
          2: m_tready <= ($urandom_range(3) == 0);
          default: m_tready <= 1'($urandom_range(1));
        endcase
      end
    end
  end

  // timeout
  always @(posedge clk) begin
    if (cycles > LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // sender and end of run
  initial begin
    query_row_t r;
    verdict_t v;
    int burst;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      r = directed[i];
      if (r.typed) begin
        v.hit = r.hit;
        v.sq_dist = r.sq_dist;
        verdict_q = {verdict_q, v};
      end
      typed_q = {typed_q, r.typed};
      offer_query(pack_query(r));
      if ($urandom_range(2) == 0) idle_gap($urandom_range(1, 4));
    end

    burst = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 900) begin
        idle_gap(1);
        while (verdict_q.size() != 0) @(negedge clk);
      end
      if (burst == 0) begin
        burst = $urandom_range(1, 40);
        if (n > 0 && $urandom_range(3) != 0) idle_gap($urandom_range(1, 12));
      end
      burst--;
      offer_query(pack_query(random_query()));
    end
    idle_gap(1);

    while (verdict_q.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire
